>>> rtl/gmed_pkg.sv
// Shared constants, types and gradient functions of the edge detector.
`timescale 1ns / 1ps
`default_nettype none
package gmed_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int PixW     = 8;
  localparam int FwW      = 11;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;
  localparam int GradW    = PixW + 4;
  localparam int SqW      = 2 * PixW + 2;
  localparam int RootW    = SqW / 2;
  localparam int RemW     = RootW + 3;

  localparam logic [CfgIdxW-1:0] CfgMode       = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgThreshold  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgFrameWidth = CfgIdxW'(2);

  typedef enum logic [ModeW-1:0] {
    ModeRoberts = 2'd0,
    ModePrewitt = 2'd1,
    ModeSobel   = 2'd2
  } mode_e;

  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhLater  = 2'd2;

  localparam logic [ModeW-1:0] ModeRst = ModeSobel;
  localparam logic [PixW-1:0]  ThrRst  = PixW'(70);
  localparam logic [FwW-1:0]   FwRst   = FwW'(512);
  localparam logic [FwW-1:0]   FwMin   = FwW'(2);
  localparam logic [FwW-1:0]   FwMax   = FwW'(MaxWidth);

  // one window column: index 0 top, 1 middle, 2 bottom
  typedef logic [2:0][PixW-1:0] col_t;

  typedef struct packed {
    logic [PixW-1:0] a1;
    logic [PixW-1:0] a2;
    logic            eor;
    logic            eof;
  } job_t;

  function automatic logic signed [GradW-1:0] ext(logic [PixW-1:0] p);
    return signed'({{(GradW-PixW){1'b0}}, p});
  endfunction

  function automatic logic [PixW-1:0] abs_sat(logic signed [GradW-1:0] g);
    logic signed [GradW-1:0] a;
    a = (g < 0) ? -g : g;
    return (a > GradW'(255)) ? {PixW{1'b1}} : a[PixW-1:0];
  endfunction

  function automatic job_t grad_job(logic [ModeW-1:0] mode, col_t lf, col_t ce, col_t rt,
                                    logic eor, logic eof);
    logic signed [GradW-1:0] g1;
    logic signed [GradW-1:0] g2;
    logic signed [GradW-1:0] d1;
    logic signed [GradW-1:0] d2;
    job_t j;
    d1 = ext(ce[2]) - ext(ce[0]);
    d2 = ext(rt[1]) - ext(lf[1]);
    if (mode == ModeRoberts) begin
      g1 = ext(rt[2]) - ext(ce[1]);
      g2 = ext(ce[2]) - ext(rt[1]);
    end else begin
      if (mode != ModePrewitt) begin
        d1 = d1 + d1;
        d2 = d2 + d2;
      end
      g1 = ext(lf[2]) - ext(lf[0]) + d1 + ext(rt[2]) - ext(rt[0]);
      g2 = ext(rt[0]) - ext(lf[0]) + d2 + ext(rt[2]) - ext(lf[2]);
    end
    j.a1  = abs_sat(g1);
    j.a2  = abs_sat(g2);
    j.eor = eor;
    j.eof = eof;
    return j;
  endfunction

endpackage
`default_nettype wire

>>> rtl/gmed_if.sv
// Pixel input and edge result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface gmed_pix_if import gmed_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [PixW-1:0] pixel;
  modport source(output valid, action, pixel, input ready);
  modport sink(input valid, action, pixel, output ready);
endinterface

interface gmed_res_if import gmed_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            edge_res;
  logic [PixW-1:0] magnitude;
  logic            end_of_row;
  logic            end_of_frame;
  modport source(output valid, edge_res, magnitude, end_of_row, end_of_frame, input ready);
  modport sink(input valid, edge_res, magnitude, end_of_row, end_of_frame, output ready);
endinterface
`default_nettype wire

>>> rtl/gradient_magnitude_edge_detect.sv
// Top level of the 3x3 gradient magnitude edge detector.
//
// Pixels enter in raster order on in_if (action 0); after the last row of a
// frame one drain item (action 1) follows per column. Each item accepted at
// row r, column c releases the result for (r-1, c-1), and on the last column
// also the one for (r-1, last). Results leave on out_if with magnitude, edge
// flag, end of row and end of frame.
// Mode, threshold and frame width are written on the cfg port while idle;
// the block itself does not enforce this. One item is taken per cycle
// unless the result path stalls; the last column of a row takes a second
// pass, since both of its results go through the single gradient stage.
// The row stores are read at accept and written back as a pixel item leaves
// its first pass; an item waits until the one before it has written back.
// Reset restores mode Sobel, threshold 70, width 512 and the first-row
// phase; the row stores are not cleared and need no clearing pass.
// A stalled receiver holds the output register; the magnitude pipeline
// keeps filling its empty stages before it stops taking input.
`timescale 1ns / 1ps
`default_nettype none
module gradient_magnitude_edge_detect import gmed_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  gmed_pix_if.sink                 in_if,
  gmed_res_if.source               out_if
);

  logic [ModeW-1:0] mode_q;
  logic [PixW-1:0]  thr_q;
  logic [FwW-1:0]   fw_q;
  logic [ColW-1:0]  col_q;
  logic [1:0]       row_q;

  logic [PixW-1:0]  old_row_mem [MaxWidth];
  logic [PixW-1:0]  rec_row_mem [MaxWidth];
  logic [PixW-1:0]  rd_old_q;
  logic [PixW-1:0]  rd_rec_q;

  logic             s1_v_q;
  logic             s1_second_q;
  logic             s1_action_q;
  logic [PixW-1:0]  s1_pix_q;
  logic [ColW-1:0]  s1_c_q;
  logic [1:0]       s1_phase_q;
  logic             s1_last_q;
  logic             s1_emit_q;
  col_t             win_l_q;
  col_t             win_c_q;

  logic [FwW-1:0]   fw_eff;
  logic [1:0]       phase0;
  logic             last0;
  logic             drop0;
  logic             acc;
  logic             load;
  logic             job_present;
  logic             job_valid;
  logic             job_ready;
  logic             s1_go;
  logic             s1_first_go;
  logic             s1_leave;
  col_t             cur;
  job_t             job;

  always_comb begin
    if (fw_q < FwMin)      fw_eff = FwMin;
    else if (fw_q > FwMax) fw_eff = FwMax;
    else                   fw_eff = fw_q;
  end

  assign phase0 = row_q[1] ? PhLater : row_q;
  assign last0  = (FwW'(col_q) + FwW'(1)) >= fw_eff;
  assign drop0  = in_if.action && (phase0 == PhFirst);
  assign acc    = in_if.valid && in_if.ready;
  assign load   = acc && !drop0;

  assign job_present = s1_second_q || s1_emit_q;
  assign s1_go       = s1_v_q && (!job_present || job_ready);
  assign s1_first_go = s1_go && !s1_second_q;
  assign s1_leave    = s1_go && (s1_second_q || !(s1_emit_q && s1_last_q));
  assign in_if.ready = !s1_v_q || s1_leave;
  assign job_valid   = s1_v_q && job_present;

  always_comb begin
    cur[1] = rd_rec_q;
    if (!s1_action_q) begin
      cur[2] = s1_pix_q;
      cur[0] = (s1_phase_q == PhSecond) ? s1_pix_q : rd_old_q;
    end else begin
      cur[0] = (s1_phase_q == PhSecond) ? rd_rec_q : rd_old_q;
      cur[2] = cur[0];
    end
  end

  always_comb begin
    if (s1_second_q) begin
      job = grad_job(mode_q, win_l_q, win_c_q, win_l_q, 1'b1, s1_action_q);
    end else begin
      job = grad_job(mode_q, (s1_c_q == ColW'(1)) ? cur : win_l_q, win_c_q, cur,
                     1'b0, 1'b0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeRst;
      thr_q  <= ThrRst;
      fw_q   <= FwRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMode:       mode_q <= cfg_data_i[ModeW-1:0];
        CfgThreshold:  thr_q  <= cfg_data_i[PixW-1:0];
        CfgFrameWidth: fw_q   <= cfg_data_i[FwW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= PhFirst;
      s1_v_q      <= 1'b0;
      s1_second_q <= 1'b0;
      win_l_q     <= '0;
      win_c_q     <= '0;
    end else begin
      if (load) begin
        if (last0) begin
          col_q <= '0;
          if (in_if.action)          row_q <= PhFirst;
          else if (phase0 == PhFirst) row_q <= PhSecond;
          else                        row_q <= PhLater;
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
      if (load) begin
        s1_v_q      <= 1'b1;
        s1_second_q <= 1'b0;
      end else if (s1_leave) begin
        s1_v_q      <= 1'b0;
        s1_second_q <= 1'b0;
      end else if (s1_first_go) begin
        s1_second_q <= 1'b1;
      end
      if (s1_first_go) begin
        win_l_q <= win_c_q;
        win_c_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_action_q <= in_if.action;
      s1_pix_q    <= in_if.pixel;
      s1_c_q      <= col_q;
      s1_phase_q  <= phase0;
      s1_last_q   <= last0;
      s1_emit_q   <= (phase0 != PhFirst) && (col_q != '0);
    end
  end

  // row stores: read at accept, written back when a pixel item leaves its first pass
  always_ff @(posedge clk_i) begin
    if (load) begin
      rd_old_q <= old_row_mem[col_q];
      rd_rec_q <= rec_row_mem[col_q];
    end
    if (s1_first_go && !s1_action_q) begin
      old_row_mem[s1_c_q] <= rd_rec_q;
      rec_row_mem[s1_c_q] <= s1_pix_q;
    end
  end

  gmed_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .thr_i       (thr_q),
    .res_o       (out_if)
  );

`ifndef SYNTHESIS
  a_second_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_second_q |-> s1_last_q && s1_emit_q) else $error("bad second pass");
  a_no_early_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> !(s1_action_q && s1_phase_q == PhFirst)) else $error("drain in first row");
  a_load_first_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> s1_v_q && !s1_second_q) else $error("item not in first pass");
`endif

endmodule
`default_nettype wire

>>> rtl/gmed_mag.sv
// Magnitude pipeline: squares, bit-serial square root stages, threshold and output register.
`timescale 1ns / 1ps
`default_nettype none
module gmed_mag import gmed_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  input  wire job_t            job_i,
  input  wire logic [PixW-1:0] thr_i,
  gmed_res_if.source           res_o
);

  localparam int NP = RootW + 1;

  logic                  g_v_q;
  job_t                  g_q;
  logic [NP-1:0]         p_v_q;
  logic [SqW-1:0]        p_x_q    [NP];
  logic [RemW-1:0]       p_rem_q  [NP];
  logic [RootW-1:0]      p_root_q [NP];
  logic                  p_eor_q  [NP];
  logic                  p_eof_q  [NP];
  logic                  out_v_q;
  logic                  out_edge_q;
  logic [PixW-1:0]       out_mag_q;
  logic                  out_eor_q;
  logic                  out_eof_q;

  logic                  adv_out;
  logic [NP-1:0]         adv_p;
  logic                  adv_g;
  logic [2*PixW-1:0]     sq1;
  logic [2*PixW-1:0]     sq2;
  logic [SqW-1:0]        sq_sum;
  logic [SqW-1:0]        x_n    [NP];
  logic [RemW-1:0]       rem_n  [NP];
  logic [RootW-1:0]      root_n [NP];
  logic [PixW-1:0]       mag_d;

  always_comb begin
    adv_out      = !out_v_q || res_o.ready;
    adv_p[NP-1]  = !p_v_q[NP-1] || adv_out;
    for (int i = NP - 2; i >= 0; i--) begin
      adv_p[i] = !p_v_q[i] || adv_p[i+1];
    end
    adv_g = !g_v_q || adv_p[0];
  end

  assign job_ready_o = adv_g;

  assign sq1    = g_q.a1 * g_q.a1;
  assign sq2    = g_q.a2 * g_q.a2;
  assign sq_sum = SqW'(sq1) + SqW'(sq2);

  // one root bit per stage
  always_comb begin
    logic [RemW-1:0] rsh;
    logic [RemW-1:0] trial;
    logic            ge;
    for (int i = 0; i < NP; i++) begin
      rsh       = {p_rem_q[i][RemW-3:0], p_x_q[i][SqW-1 -: 2]};
      trial     = RemW'({p_root_q[i], 2'b01});
      ge        = rsh >= trial;
      rem_n[i]  = ge ? rsh - trial : rsh;
      root_n[i] = {p_root_q[i][RootW-2:0], ge};
      x_n[i]    = p_x_q[i] << 2;
    end
  end

  assign mag_d = (p_root_q[NP-1] > RootW'(255)) ? {PixW{1'b1}} : p_root_q[NP-1][PixW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q   <= 1'b0;
      p_v_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_g) g_v_q <= job_valid_i;
      if (adv_p[0]) p_v_q[0] <= g_v_q;
      for (int i = 1; i < NP; i++) begin
        if (adv_p[i]) p_v_q[i] <= p_v_q[i-1];
      end
      if (adv_out) out_v_q <= p_v_q[NP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_g && job_valid_i) g_q <= job_i;
    if (adv_p[0] && g_v_q) begin
      p_x_q[0]    <= sq_sum;
      p_rem_q[0]  <= '0;
      p_root_q[0] <= '0;
      p_eor_q[0]  <= g_q.eor;
      p_eof_q[0]  <= g_q.eof;
    end
    for (int i = 1; i < NP; i++) begin
      if (adv_p[i] && p_v_q[i-1]) begin
        p_x_q[i]    <= x_n[i-1];
        p_rem_q[i]  <= rem_n[i-1];
        p_root_q[i] <= root_n[i-1];
        p_eor_q[i]  <= p_eor_q[i-1];
        p_eof_q[i]  <= p_eof_q[i-1];
      end
    end
    if (adv_out && p_v_q[NP-1]) begin
      out_edge_q <= mag_d > thr_i;
      out_mag_q  <= mag_d;
      out_eor_q  <= p_eor_q[NP-1];
      out_eof_q  <= p_eof_q[NP-1];
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.edge_res     = out_edge_q;
  assign res_o.magnitude    = out_mag_q;
  assign res_o.end_of_row   = out_eor_q;
  assign res_o.end_of_frame = out_eof_q;

`ifndef SYNTHESIS
  a_empty_out_takes_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> job_ready_o) else $error("job stalled with empty output");
  a_job_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |=> g_v_q) else $error("accepted job lost");
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v_q[NP-1] |-> p_root_q[NP-1] <= RootW'(361)) else $error("root out of range");
`endif

endmodule
`default_nettype wire
